### hw/rtl/tfdr_pkg.sv
// shared types and constants for the triangle face direction reducer
package tfdr_pkg;
    localparam int COORD_BITS_DEF = 24;
    localparam int DIR_BITS       = 51;
    localparam int WORK_BITS      = 64;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_GCD,
        BK_DIV,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic signed [WORK_BITS-1:0] d_x;
        logic signed [WORK_BITS-1:0] d_y;
        logic signed [WORK_BITS-1:0] d_z;
    } cross_t;
endpackage

### hw/rtl/tfdr_front.sv
// front stage: edge vectors and cross product, one component per multiply step
module tfdr_front #(
    parameter int COORD_BITS = tfdr_pkg::COORD_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [9*COORD_BITS-1:0]    in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output tfdr_pkg::cross_t           out_cross
);
    localparam int W  = tfdr_pkg::WORK_BITS;
    localparam int EB = COORD_BITS + 1;

    logic                    busy_reg, busy_next;
    logic [2:0]              step_reg, step_next;
    logic signed [EB-1:0]    ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [W-1:0]     p_reg, q_reg;
    tfdr_pkg::cross_t        res_reg;
    logic                    done_reg, done_next;

    logic signed [COORD_BITS-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    assign ax = in_data[0*COORD_BITS +: COORD_BITS];
    assign ay = in_data[1*COORD_BITS +: COORD_BITS];
    assign az = in_data[2*COORD_BITS +: COORD_BITS];
    assign bx = in_data[3*COORD_BITS +: COORD_BITS];
    assign by = in_data[4*COORD_BITS +: COORD_BITS];
    assign bz = in_data[5*COORD_BITS +: COORD_BITS];
    assign cx = in_data[6*COORD_BITS +: COORD_BITS];
    assign cy = in_data[7*COORD_BITS +: COORD_BITS];
    assign cz = in_data[8*COORD_BITS +: COORD_BITS];

    // one pair of products per step
    logic signed [EB-1:0] m1a, m1b, m2a, m2b;
    always_comb begin
        case (step_reg)
            3'd0: begin
                m1a = uy_reg; m1b = vz_reg; m2a = uz_reg; m2b = vy_reg;
            end
            3'd1: begin
                m1a = uz_reg; m1b = vx_reg; m2a = ux_reg; m2b = vz_reg;
            end
            default: begin
                m1a = ux_reg; m1b = vy_reg; m2a = uy_reg; m2b = vx_reg;
            end
        endcase
    end

    logic signed [2*EB-1:0] prod1, prod2;
    assign prod1 = m1a * m1b;
    assign prod2 = m2a * m2b;

    assign in_ready  = !busy_reg && !done_reg;
    assign out_valid = done_reg;
    assign out_cross = res_reg;

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = done_reg;
        if (in_valid && in_ready) begin
            busy_next = 1'b1;
            step_next = 3'd0;
        end else if (busy_reg) begin
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd3) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (done_reg && out_ready) begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            ux_reg <= EB'(cx) - EB'(ax);
            uy_reg <= EB'(cy) - EB'(ay);
            uz_reg <= EB'(cz) - EB'(az);
            vx_reg <= EB'(bx) - EB'(ax);
            vy_reg <= EB'(by) - EB'(ay);
            vz_reg <= EB'(bz) - EB'(az);
        end
        if (busy_reg) begin
            p_reg <= W'(prod1);
            q_reg <= W'(prod2);
            case (step_reg)
                3'd1:    res_reg.d_x <= p_reg - q_reg;
                3'd2:    res_reg.d_y <= p_reg - q_reg;
                3'd3:    res_reg.d_z <= p_reg - q_reg;
                default: ;
            endcase
        end
    end
endmodule

### hw/rtl/tfdr_queue.sv
// small fifo between front and back
module tfdr_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  tfdr_pkg::cross_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tfdr_pkg::cross_t  out_data
);
    localparam int D  = tfdr_pkg::QUEUE_DEPTH;
    localparam int AB = $clog2(D);

    tfdr_pkg::cross_t mem_reg [D];
    logic [AB-1:0]    wr_reg, rd_reg;
    logic [AB:0]      cnt_reg;
    logic             push, pop;

    assign in_ready  = cnt_reg != (AB+1)'(D);
    assign out_valid = cnt_reg != '0;
    assign out_data  = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= (wr_reg == AB'(D-1)) ? '0 : wr_reg + 1'b1;
            if (pop)  rd_reg <= (rd_reg == AB'(D-1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AB+1)'(push) - (AB+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= in_data;
    end
endmodule

### hw/rtl/tfdr_back.sv
// back stage: binary gcd of magnitudes, then restoring divisions when the gcd exceeds one
module tfdr_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  tfdr_pkg::cross_t                     in_cross,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [3*tfdr_pkg::DIR_BITS-1:0]      out_dir,
    output logic                                 out_degenerate
);
    localparam int W  = tfdr_pkg::WORK_BITS;
    localparam int DB = tfdr_pkg::DIR_BITS;
    localparam int SB = $clog2(W) + 1;
    localparam int CB = $clog2(W);

    tfdr_pkg::back_state_t state_reg, state_next;

    logic [W-1:0]  mag_reg [3];
    logic [2:0]    neg_reg;
    logic [W-1:0]  ga_reg, gb_reg;
    logic [SB-1:0] sh_reg;
    logic [1:0]    gidx_reg;
    logic [W-1:0]  div_reg;
    logic [1:0]    didx_reg;
    logic [CB-1:0] bit_reg;
    logic [W-1:0]  rem_reg, quo_reg;
    logic [W-1:0]  res_reg [3];
    logic          deg_reg;
    logic          gcd_done, div_last;

    // gcd step: binary algorithm on ga/gb; gb==0 means current gcd is ga shifted left by sh
    logic [W-1:0] ga_n, gb_n;
    logic [SB-1:0] sh_n;
    logic          gstep_done;
    always_comb begin
        ga_n = ga_reg;
        gb_n = gb_reg;
        sh_n = sh_reg;
        gstep_done = 1'b0;
        if (gb_reg == '0) begin
            gstep_done = 1'b1;
        end else if (ga_reg == '0) begin
            ga_n = gb_reg;
            gb_n = '0;
        end else if (!ga_reg[0] && !gb_reg[0]) begin
            ga_n = ga_reg >> 1;
            gb_n = gb_reg >> 1;
            sh_n = sh_reg + 1'b1;
        end else if (!ga_reg[0]) begin
            ga_n = ga_reg >> 1;
        end else if (!gb_reg[0]) begin
            gb_n = gb_reg >> 1;
        end else if (ga_reg >= gb_reg) begin
            ga_n = (ga_reg - gb_reg) >> 1;
        end else begin
            gb_n = (gb_reg - ga_reg) >> 1;
        end
    end

    logic [W-1:0] gfull;
    assign gfull    = ga_reg << sh_reg;
    assign gcd_done = gstep_done && (gidx_reg == 2'd2);

    logic [W:0] trial;
    assign trial    = {rem_reg, quo_reg[W-1]} - {1'b0, div_reg};
    assign div_last = (bit_reg == CB'(W-1)) && (didx_reg == 2'd2);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tfdr_pkg::BK_IDLE: if (in_valid) state_next = tfdr_pkg::BK_GCD;
            tfdr_pkg::BK_GCD: begin
                if (gcd_done) begin
                    state_next = (gfull > W'(1)) ? tfdr_pkg::BK_DIV : tfdr_pkg::BK_OUT;
                end
            end
            tfdr_pkg::BK_DIV: if (div_last) state_next = tfdr_pkg::BK_OUT;
            tfdr_pkg::BK_OUT: if (out_ready) state_next = tfdr_pkg::BK_IDLE;
            default: state_next = tfdr_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = state_reg == tfdr_pkg::BK_IDLE;
        out_valid = state_reg == tfdr_pkg::BK_OUT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= tfdr_pkg::BK_IDLE;
        else          state_reg <= state_next;
    end

    logic [W-1:0] sx, sy, sz;
    assign sx = neg_reg[0] ? -res_reg[0] : res_reg[0];
    assign sy = neg_reg[1] ? -res_reg[1] : res_reg[1];
    assign sz = neg_reg[2] ? -res_reg[2] : res_reg[2];
    assign out_dir = {sz[DB-1:0], sy[DB-1:0], sx[DB-1:0]};
    assign out_degenerate = deg_reg;

    always_ff @(posedge aclk) begin
        case (state_reg)
            tfdr_pkg::BK_IDLE: begin
                if (in_valid) begin
                    neg_reg   <= {in_cross.d_z[W-1], in_cross.d_y[W-1], in_cross.d_x[W-1]};
                    mag_reg[0] <= in_cross.d_x[W-1] ? -in_cross.d_x : in_cross.d_x;
                    mag_reg[1] <= in_cross.d_y[W-1] ? -in_cross.d_y : in_cross.d_y;
                    mag_reg[2] <= in_cross.d_z[W-1] ? -in_cross.d_z : in_cross.d_z;
                    ga_reg    <= in_cross.d_x[W-1] ? -in_cross.d_x : in_cross.d_x;
                    gb_reg    <= in_cross.d_y[W-1] ? -in_cross.d_y : in_cross.d_y;
                    sh_reg    <= '0;
                    gidx_reg  <= 2'd1;
                end
            end
            tfdr_pkg::BK_GCD: begin
                if (gstep_done) begin
                    if (gidx_reg == 2'd1) begin
                        // fold in the third component
                        ga_reg   <= gfull;
                        gb_reg   <= mag_reg[2];
                        sh_reg   <= '0;
                        gidx_reg <= 2'd2;
                    end else begin
                        div_reg    <= gfull;
                        deg_reg    <= gfull == '0;
                        res_reg[0] <= mag_reg[0];
                        res_reg[1] <= mag_reg[1];
                        res_reg[2] <= mag_reg[2];
                        didx_reg   <= 2'd0;
                        bit_reg    <= '0;
                        rem_reg    <= '0;
                        quo_reg    <= mag_reg[0];
                    end
                end else begin
                    ga_reg <= ga_n;
                    gb_reg <= gb_n;
                    sh_reg <= sh_n;
                end
            end
            tfdr_pkg::BK_DIV: begin
                // one quotient bit per cycle, shifted into quo_reg
                if (bit_reg == CB'(W-1)) begin
                    res_reg[didx_reg] <= {quo_reg[W-2:0], !trial[W]};
                    bit_reg  <= '0;
                    rem_reg  <= '0;
                    if (didx_reg != 2'd2) begin
                        didx_reg <= didx_reg + 1'b1;
                        quo_reg  <= mag_reg[didx_reg + 1'b1];
                    end else begin
                        quo_reg  <= {quo_reg[W-2:0], !trial[W]};
                    end
                end else begin
                    bit_reg <= bit_reg + 1'b1;
                    rem_reg <= trial[W] ? {rem_reg[W-2:0], quo_reg[W-1]} : trial[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], !trial[W]};
                end
            end
            default: ;
        endcase
    end
endmodule

### hw/rtl/triangle_face_direction_reduce_top.sv
// top level: triangle cross product reduced by the gcd of its components
// path: front cross product, the queue, then binary gcd in the back stage and,
// when the divisor exceeds one, bit-serial division of each of the three components;
// a degenerate triangle (divisor zero) skips the division
// throughput: one transaction per back-stage pass, set by the gcd loop and divider;
// the front takes the next triangle while the back works, through a 2-entry queue
// reset: aresetn synchronous active low clears all handshake and sequencer state
module triangle_face_direction_reduce_top #(
    parameter int COORD_BITS = tfdr_pkg::COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero pad to bytes
    input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // dir_x, dir_y, dir_z, zero pad to bytes
    output logic [159:0]                      m_tdata,
    // degenerate
    output logic                              m_tuser
);
    logic             f_valid, f_ready, q_valid, q_ready;
    tfdr_pkg::cross_t f_cross, q_cross;
    logic [3*tfdr_pkg::DIR_BITS-1:0] dir;

    tfdr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_data(s_tdata[9*COORD_BITS-1:0]),
        .out_valid(f_valid), .out_ready(f_ready), .out_cross(f_cross)
    );

    tfdr_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_cross),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_cross)
    );

    tfdr_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_cross(q_cross),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_dir(dir), .out_degenerate(m_tuser)
    );

    assign m_tdata = {7'd0, dir};
endmodule
